// File: rtl/timer_rate_calibrate_and_convert_assert.svh
// Assertion macros for the timer rate calibration block.
// Used by timer_rate_calibrate_and_convert.sv; expects clk and rst_n in scope.
`ifndef TIMER_RATE_CALIBRATE_AND_CONVERT_ASSERT_SVH
`define TIMER_RATE_CALIBRATE_AND_CONVERT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while in reset.
`define TRCC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trcc assertion failed");
// Next-cycle implication, disabled while in reset.
`define TRCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trcc assertion failed");
`else
`define TRCC_ASSERT_IMPL(label, ante, cons)
`define TRCC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/trcc_pkg.sv
// Shared types and constants for the timer rate calibration block.
// No dependencies; imported by trcc_mul, trcc_div and the top level.
package trcc_pkg;

    localparam int unsigned MUL_STEPS = 32;
    localparam int unsigned DIV_STEPS = 64;
    localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_STEPS - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    localparam logic [63:0] NS_PER_SEC   = 64'd1000000000;
    localparam logic [31:0] REF_HZ_RESET = 32'd3579545;

    typedef enum logic [1:0] {
        OP_CALIBRATE = 2'd0,
        OP_FREQUENCY = 2'd1,
        OP_INTERVAL  = 2'd2,
        OP_NOP       = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK                 = 3'd0,
        ST_BAD_INTERVAL       = 3'd1,
        ST_BAD_FREQUENCY      = 3'd2,
        ST_EXHAUSTED          = 3'd3,
        ST_NOT_COUNTING       = 3'd4,
        ST_NOT_CALIBRATED     = 3'd5,
        ST_ALREADY_CALIBRATED = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_CAL_MUL,
        SEQ_CAL_DIV,
        SEQ_FRQ_DIV,
        SEQ_INT_SDIV,
        SEQ_INT_SMUL,
        SEQ_INT_RDIV,
        SEQ_INT_QMUL,
        SEQ_INT_RMUL,
        SEQ_INT_FDIV,
        SEQ_INT_SUM,
        SEQ_FINISH
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// File: rtl/trcc_div.sv
// Bit-serial restoring divider, 64 by 64 bits, one quotient bit per cycle.
// Depends on trcc_pkg.
module trcc_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [63:0]           dividend,
    input  logic [63:0]           divisor,
    output trcc_pkg::unit_stat_t  stat,
    output logic [63:0]           quot,
    output logic [63:0]           rem
);
    import trcc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0]          quo_reg, quo_next;
    logic [63:0]          rem_reg, rem_next;
    logic [63:0]          dsr_reg, dsr_next;
    logic [64:0]          trial;
    logic [64:0]          diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[63]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            if (!diff[64])
            begin
                rem_next = diff[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quo_reg;
    assign rem       = rem_reg;

endmodule

// File: rtl/trcc_mul.sv
// Bit-serial shift-add multiplier, 32 by 32 bits, one multiplier bit per cycle.
// Depends on trcc_pkg.
module trcc_mul (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [31:0]           mplier,
    input  logic [31:0]           mcand,
    output trcc_pkg::unit_stat_t  stat,
    output logic [63:0]           prod
);
    import trcc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [63:0]          acc_reg, acc_next;
    logic [63:0]          mcd_reg, mcd_next;
    logic [31:0]          mpl_reg, mpl_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mcd_next  = mcd_reg;
        mpl_next  = mpl_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            mcd_next  = {32'd0, mcand};
            mpl_next  = mplier;
        end
        else if (busy_reg)
        begin
            if (mpl_reg[0])
            begin
                acc_next = acc_reg + mcd_reg;
            end
            mcd_next = {mcd_reg[62:0], 1'b0};
            mpl_next = {1'b0, mpl_reg[31:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mcd_reg <= mcd_next;
        mpl_reg <= mpl_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = acc_reg;

endmodule

// File: rtl/timer_rate_calibrate_and_convert.sv
// Timer rate calibration and count conversion, top level.
// Depends on trcc_pkg, trcc_mul, trcc_div and the assertion macro header.
//
// One item at a time: an item is taken only while the sequencer is idle and
// its result lands in an output register, so the next item may be taken while
// that result waits. Work runs on one shared bit-serial multiplier (32 steps)
// and one restoring divider (64 steps, one quotient bit per cycle). A refused
// item uses neither unit; a frequency conversion is one divide; a calibration
// a multiply, then a divide by the ticks; an interval conversion at most a
// divide by 1e9, a multiply of the seconds, a divide of the rate by 1e9, two
// multiplies and a final divide of the sub-second part. A result held in a
// full output register stalls the next item until it is taken. The stored
// rate is set once by a successful calibration and kept until reset.
`include "timer_rate_calibrate_and_convert_assert.svh"

module timer_rate_calibrate_and_convert (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [31:0] start_count,
    input  logic [31:0] end_count,
    input  logic [63:0] window_ticks,
    input  logic [31:0] periodic_freq,
    input  logic [63:0] interval_ns,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] count,
    output logic [63:0] rate
);
    import trcc_pkg::*;

    seq_state_t  state_reg, state_next;
    logic [31:0] ref_hz_reg, ref_hz_next;
    logic [63:0] counts_rate_reg, counts_rate_next;
    logic        rate_valid_reg, rate_valid_next;
    logic        out_valid_reg, out_valid_next;

    logic [63:0] ticks_reg, ticks_next;
    logic [29:0] rem_ns_reg, rem_ns_next;
    logic [29:0] rr_reg, rr_next;
    logic [31:0] secprod_reg, secprod_next;
    logic [32:0] frac_reg, frac_next;
    status_t     res_status_reg, res_status_next;
    logic [31:0] res_count_reg, res_count_next;
    status_t     status_reg, status_next;
    logic [31:0] count_reg, count_next;
    logic [63:0] rate_reg, rate_next;

    logic        mul_start;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_prod;
    unit_stat_t  mul_stat;
    logic        div_start;
    logic [63:0] div_n, div_d;
    logic [63:0] div_quot, div_rem;
    unit_stat_t  div_stat;

    logic        fin_en;
    status_t     fin_st;
    logic [31:0] fin_cnt;
    logic [33:0] total;

    trcc_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .mplier (mul_a),
        .mcand  (mul_b),
        .stat   (mul_stat),
        .prod   (mul_prod)
    );

    trcc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .stat     (div_stat),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == SEQ_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign count     = count_reg;
    assign rate      = rate_reg;

    always_comb
    begin
        state_next       = state_reg;
        ref_hz_next      = ref_hz_reg;
        counts_rate_next = counts_rate_reg;
        rate_valid_next  = rate_valid_reg;
        out_valid_next   = out_valid_reg;
        ticks_next       = ticks_reg;
        rem_ns_next      = rem_ns_reg;
        rr_next          = rr_reg;
        secprod_next     = secprod_reg;
        frac_next        = frac_reg;
        res_status_next  = res_status_reg;
        res_count_next   = res_count_reg;
        status_next      = status_reg;
        count_next       = count_reg;
        rate_next        = rate_reg;
        mul_start        = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        div_start        = 1'b0;
        div_n            = '0;
        div_d            = '0;
        fin_en           = 1'b0;
        fin_st           = ST_OK;
        fin_cnt          = '0;
        total            = {2'b00, secprod_reg} + {1'b0, frac_reg};

        if (cfg_valid && cfg_ready)
        begin
            ref_hz_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (opcode_t'(opcode))
                        OP_CALIBRATE:
                        begin
                            if (rate_valid_reg)
                            begin
                                fin_en = 1'b1;
                                fin_st = ST_ALREADY_CALIBRATED;
                            end
                            else if (ref_hz_reg == '0 || window_ticks == '0)
                            begin
                                fin_en = 1'b1;
                                fin_st = ST_BAD_FREQUENCY;
                            end
                            else if (end_count == '0)
                            begin
                                fin_en = 1'b1;
                                fin_st = ST_EXHAUSTED;
                            end
                            else if (start_count <= end_count)
                            begin
                                fin_en = 1'b1;
                                fin_st = ST_NOT_COUNTING;
                            end
                            else
                            begin
                                mul_start  = 1'b1;
                                mul_a      = start_count - end_count;
                                mul_b      = ref_hz_reg;
                                ticks_next = window_ticks;
                                state_next = SEQ_CAL_MUL;
                            end
                        end
                        OP_FREQUENCY:
                        begin
                            if (!rate_valid_reg)
                            begin
                                fin_en = 1'b1;
                                fin_st = ST_NOT_CALIBRATED;
                            end
                            else if (periodic_freq == '0)
                            begin
                                fin_en = 1'b1;
                                fin_st = ST_BAD_FREQUENCY;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                div_n      = counts_rate_reg;
                                div_d      = {32'd0, periodic_freq};
                                state_next = SEQ_FRQ_DIV;
                            end
                        end
                        OP_INTERVAL:
                        begin
                            if (!rate_valid_reg)
                            begin
                                fin_en = 1'b1;
                                fin_st = ST_NOT_CALIBRATED;
                            end
                            else if (interval_ns == '0)
                            begin
                                fin_en = 1'b1;
                                fin_st = ST_BAD_INTERVAL;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                div_n      = interval_ns;
                                div_d      = NS_PER_SEC;
                                state_next = SEQ_INT_SDIV;
                            end
                        end
                        OP_NOP:
                        begin
                            fin_en = 1'b1;
                            fin_st = ST_OK;
                        end
                    endcase
                end
            end
            SEQ_CAL_MUL:
            begin
                if (mul_stat.done)
                begin
                    div_start  = 1'b1;
                    div_n      = mul_prod;
                    div_d      = ticks_reg;
                    state_next = SEQ_CAL_DIV;
                end
            end
            SEQ_CAL_DIV:
            begin
                if (div_stat.done)
                begin
                    fin_en = 1'b1;
                    if (div_quot == '0)
                    begin
                        fin_st = ST_NOT_COUNTING;
                    end
                    else
                    begin
                        counts_rate_next = div_quot;
                        rate_valid_next  = 1'b1;
                    end
                end
            end
            SEQ_FRQ_DIV:
            begin
                if (div_stat.done)
                begin
                    fin_en = 1'b1;
                    if (div_quot == '0 || div_quot[63:32] != '0)
                    begin
                        fin_st = ST_BAD_FREQUENCY;
                    end
                    else
                    begin
                        fin_cnt = div_quot[31:0];
                    end
                end
            end
            SEQ_INT_SDIV:
            begin
                if (div_stat.done)
                begin
                    rem_ns_next = div_rem[29:0];
                    frac_next   = '0;
                    if (div_quot == '0)
                    begin
                        // no whole seconds: remainder is the whole interval, never zero
                        secprod_next = '0;
                        div_start    = 1'b1;
                        div_n        = counts_rate_reg;
                        div_d        = NS_PER_SEC;
                        state_next   = SEQ_INT_RDIV;
                    end
                    else if (div_quot[63:32] != '0 || counts_rate_reg[63:32] != '0)
                    begin
                        fin_en = 1'b1;
                        fin_st = ST_BAD_INTERVAL;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        mul_a      = div_quot[31:0];
                        mul_b      = counts_rate_reg[31:0];
                        state_next = SEQ_INT_SMUL;
                    end
                end
            end
            SEQ_INT_SMUL:
            begin
                if (mul_stat.done)
                begin
                    if (mul_prod[63:32] != '0)
                    begin
                        fin_en = 1'b1;
                        fin_st = ST_BAD_INTERVAL;
                    end
                    else
                    begin
                        secprod_next = mul_prod[31:0];
                        if (rem_ns_reg == '0)
                        begin
                            state_next = SEQ_INT_SUM;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            div_n      = counts_rate_reg;
                            div_d      = NS_PER_SEC;
                            state_next = SEQ_INT_RDIV;
                        end
                    end
                end
            end
            SEQ_INT_RDIV:
            begin
                if (div_stat.done)
                begin
                    if (div_quot[63:32] != '0)
                    begin
                        fin_en = 1'b1;
                        fin_st = ST_BAD_INTERVAL;
                    end
                    else
                    begin
                        rr_next    = div_rem[29:0];
                        mul_start  = 1'b1;
                        mul_a      = {2'b00, rem_ns_reg};
                        mul_b      = div_quot[31:0];
                        state_next = SEQ_INT_QMUL;
                    end
                end
            end
            SEQ_INT_QMUL:
            begin
                if (mul_stat.done)
                begin
                    if (mul_prod[63:32] != '0)
                    begin
                        fin_en = 1'b1;
                        fin_st = ST_BAD_INTERVAL;
                    end
                    else
                    begin
                        frac_next  = {1'b0, mul_prod[31:0]};
                        mul_start  = 1'b1;
                        mul_a      = {2'b00, rem_ns_reg};
                        mul_b      = {2'b00, rr_reg};
                        state_next = SEQ_INT_RMUL;
                    end
                end
            end
            SEQ_INT_RMUL:
            begin
                if (mul_stat.done)
                begin
                    div_start  = 1'b1;
                    div_n      = mul_prod;
                    div_d      = NS_PER_SEC;
                    state_next = SEQ_INT_FDIV;
                end
            end
            SEQ_INT_FDIV:
            begin
                if (div_stat.done)
                begin
                    // quotient stays below 1e9, so 30 bits carry it
                    frac_next  = frac_reg + {3'b000, div_quot[29:0]};
                    state_next = SEQ_INT_SUM;
                end
            end
            SEQ_INT_SUM:
            begin
                fin_en = 1'b1;
                if (total == '0 || total[33:32] != '0)
                begin
                    fin_st = ST_BAD_INTERVAL;
                end
                else
                begin
                    fin_cnt = total[31:0];
                end
            end
            SEQ_FINISH:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    count_next     = res_count_reg;
                    rate_next      = counts_rate_reg;
                    state_next     = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase

        if (fin_en)
        begin
            res_status_next = fin_st;
            res_count_next  = (fin_st == ST_OK) ? fin_cnt : '0;
            state_next      = SEQ_FINISH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= SEQ_IDLE;
            ref_hz_reg      <= REF_HZ_RESET;
            counts_rate_reg <= '0;
            rate_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ref_hz_reg      <= ref_hz_next;
            counts_rate_reg <= counts_rate_next;
            rate_valid_reg  <= rate_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ticks_reg      <= ticks_next;
        rem_ns_reg     <= rem_ns_next;
        rr_reg         <= rr_next;
        secprod_reg    <= secprod_next;
        frac_reg       <= frac_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        status_reg     <= status_next;
        count_reg      <= count_next;
        rate_reg       <= rate_next;
    end

    `TRCC_ASSERT_IMPL(a_rate_nonzero, rate_valid_reg, counts_rate_reg != '0)
    `TRCC_ASSERT_NEXT(a_rate_sticky, rate_valid_reg, rate_valid_reg)
    `TRCC_ASSERT_IMPL(a_one_unit_busy, 1'b1, !(mul_stat.busy && div_stat.busy))
    `TRCC_ASSERT_IMPL(a_refused_no_count, out_valid && status != ST_OK, count == '0)
    `TRCC_ASSERT_IMPL(a_idle_units, state_reg == SEQ_IDLE, !mul_stat.busy && !div_stat.busy)

endmodule
